@@ rtl/number_to_english_words_unit_defines.svh @@
// Assertion macros shared by the number-to-words block.
`ifndef NUMBER_TO_ENGLISH_WORDS_UNIT_DEFINES_SVH
`define NUMBER_TO_ENGLISH_WORDS_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define NTEW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define NTEW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/ntew_pkg.sv @@
// Types and constants shared by the number-to-words block.
`default_nettype none

package ntew_pkg;

  localparam int VALUE_W  = 40;
  localparam int DIGITS   = 12;
  localparam int BCD_W    = DIGITS * 4;
  localparam int GROUPS   = 4;
  localparam int PHASES   = 5;
  localparam int WORD_W   = 5;
  localparam int SEP_W    = 2;

  localparam logic [VALUE_W-1:0] MAX_VALUE = 40'd999999999999;

  localparam logic [WORD_W-1:0] TOK_ZERO     = 5'd0;
  localparam logic [WORD_W-1:0] TOK_TEEN     = 5'd10;
  localparam logic [WORD_W-1:0] TOK_TENS     = 5'd18;
  localparam logic [WORD_W-1:0] TOK_HUNDRED  = 5'd28;
  localparam logic [WORD_W-1:0] TOK_THOUSAND = 5'd29;
  localparam logic [WORD_W-1:0] TOK_MILLION  = 5'd30;
  localparam logic [WORD_W-1:0] TOK_BILLION  = 5'd31;

  typedef enum logic [SEP_W-1:0] {
    SEP_NONE   = 2'd0,
    SEP_SPACE  = 2'd1,
    SEP_HYPHEN = 2'd2
  } sep_t;

  typedef enum logic [1:0] {
    GRP_BILLION  = 2'd0,
    GRP_MILLION  = 2'd1,
    GRP_THOUSAND = 2'd2,
    GRP_UNITS    = 2'd3
  } grp_t;

  typedef enum logic [2:0] {
    PH_HUND_DIGIT = 3'd0,
    PH_HUNDRED    = 3'd1,
    PH_TENS       = 3'd2,
    PH_ONES       = 3'd3,
    PH_SCALE      = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_CONV  = 2'd1,
    ST_SPELL = 2'd2
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } conv_stat_t;

  typedef struct packed {
    logic start;
    logic too_big;
  } spell_ctl_t;

endpackage

`default_nettype wire

@@ rtl/number_to_english_words_unit.sv @@
// Top level of the number-to-words block: control sequencer, converter and speller.
//
// Each accepted value beat is spelled as a run of word beats, the last one
// marked by last. A value beat is accepted in idle and converted by the
// shift-and-add-three converter, and then the speller is started; it visits
// one group and phase slot per cycle while the output is not stalled, up to
// 19 slots up to the final word (a zero value or a value above 999999999999
// gives its single beat in the first slot), and then the block returns to
// idle. The input is stalled from acceptance until the cycle after the final
// word is loaded into the output register; that word may still wait there
// while the next value is taken.
`default_nettype none

module number_to_english_words_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              value_valid,
  output logic                                   value_stall,
  input  wire logic [ntew_pkg::VALUE_W-1:0]      value,
  output logic                                   word_valid,
  input  wire logic                              word_stall,
  output logic      [ntew_pkg::WORD_W-1:0]       word,
  output logic      [ntew_pkg::SEP_W-1:0]        separator,
  output logic                                   too_big,
  output logic                                   last
);

  `include "number_to_english_words_unit_defines.svh"

  ntew_pkg::state_t     state;
  ntew_pkg::state_t     state_next;
  ntew_pkg::conv_stat_t conv_stat;
  ntew_pkg::spell_ctl_t spell_ctl;
  logic [ntew_pkg::BCD_W-1:0] bcd;
  logic                 accept;
  logic                 spell_done;
  logic                 big;

  always_comb begin
    state_next = state;
    case (state)
      ntew_pkg::ST_IDLE:  if (value_valid) state_next = ntew_pkg::ST_CONV;
      ntew_pkg::ST_CONV:  if (conv_stat.done) state_next = ntew_pkg::ST_SPELL;
      ntew_pkg::ST_SPELL: if (spell_done) state_next = ntew_pkg::ST_IDLE;
      default:            state_next = ntew_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    value_stall       = (state != ntew_pkg::ST_IDLE);
    accept            = value_valid && (state == ntew_pkg::ST_IDLE);
    spell_ctl.start   = (state == ntew_pkg::ST_CONV) && conv_stat.done;
    spell_ctl.too_big = big;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ntew_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      big <= value > ntew_pkg::MAX_VALUE;
    end
  end

  ntew_dabble u_dabble (
    .clk    (clk),
    .rst    (rst),
    .start  (accept),
    .bin_in (value),
    .stat   (conv_stat),
    .bcd    (bcd)
  );

  ntew_speller u_speller (
    .clk        (clk),
    .rst        (rst),
    .ctl        (spell_ctl),
    .bcd        (bcd),
    .word_stall (word_stall),
    .word_valid (word_valid),
    .word       (word),
    .separator  (separator),
    .too_big    (too_big),
    .last       (last),
    .done       (spell_done)
  );

  `NTEW_ASSERT_NOW(a_err_single, word_valid && too_big, last && (word == ntew_pkg::TOK_ZERO) && (separator == ntew_pkg::SEP_NONE), "error beat must be a lone final beat")
  `NTEW_ASSERT_NOW(a_conv_in_state, conv_stat.done, state == ntew_pkg::ST_CONV, "conversion finished outside the convert state")
  `NTEW_ASSERT_NOW(a_idle_quiet, state == ntew_pkg::ST_IDLE, !conv_stat.busy, "converter busy while idle")
  `NTEW_ASSERT_NOW(a_spell_end, spell_done, (state == ntew_pkg::ST_SPELL) && word_valid && last, "speller finished without a final beat")

endmodule

`default_nettype wire

@@ rtl/ntew_dabble.sv @@
// Iterative shift-and-add-three binary to decimal converter.
`default_nettype none

module ntew_dabble (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire logic [ntew_pkg::VALUE_W-1:0]    bin_in,
  output ntew_pkg::conv_stat_t                 stat,
  output logic      [ntew_pkg::BCD_W-1:0]      bcd
);

  localparam int CNT_W = $clog2(ntew_pkg::VALUE_W + 1);

  logic [ntew_pkg::VALUE_W-1:0] bin;
  logic [ntew_pkg::BCD_W-1:0]   bcd_adj;
  logic [CNT_W-1:0]             cnt;
  logic                         busy;
  logic                         done;

  always_comb begin
    for (int i = 0; i < ntew_pkg::DIGITS; i++) begin
      if (bcd[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd[i*4 +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(ntew_pkg::VALUE_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      bin <= bin_in;
      bcd <= '0;
    end else if (busy) begin
      bin <= {bin[ntew_pkg::VALUE_W-2:0], 1'b0};
      bcd <= {bcd_adj[ntew_pkg::BCD_W-2:0], bin[ntew_pkg::VALUE_W-1]};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

`default_nettype wire

@@ rtl/ntew_speller.sv @@
// Token sequencer that walks the digit groups and drives the word output register.
`default_nettype none

module ntew_speller (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire ntew_pkg::spell_ctl_t          ctl,
  input  wire logic [ntew_pkg::BCD_W-1:0]    bcd,
  input  wire logic                          word_stall,
  output logic                               word_valid,
  output logic      [ntew_pkg::WORD_W-1:0]   word,
  output logic      [ntew_pkg::SEP_W-1:0]    separator,
  output logic                               too_big,
  output logic                               last,
  output logic                               done
);

  logic [ntew_pkg::GROUPS-1:0][11:0]                 groups;
  logic [ntew_pkg::GROUPS-1:0][ntew_pkg::PHASES-1:0] flags_new;
  logic [ntew_pkg::GROUPS-1:0][ntew_pkg::PHASES-1:0] flags;
  logic [ntew_pkg::GROUPS-1:0][ntew_pkg::PHASES-1:0] later;

  ntew_pkg::grp_t   grp;
  ntew_pkg::phase_t ph;
  logic             active;
  logic             special;
  logic             err;
  logic             first;

  logic [3:0]                  dh;
  logic [3:0]                  dt;
  logic [3:0]                  dl;
  logic                        cur_flag;
  logic                        cur_last;
  logic [ntew_pkg::WORD_W-1:0] cur_word;
  ntew_pkg::sep_t              cur_sep;
  logic                        out_free;
  logic                        step;
  logic                        emit;
  logic                        finish;

  always_comb begin
    for (int g = 0; g < ntew_pkg::GROUPS; g++) begin
      groups[g] = bcd[(ntew_pkg::GROUPS-1-g)*12 +: 12];
      flags_new[g][ntew_pkg::PH_HUND_DIGIT] = groups[g][11:8] != 4'd0;
      flags_new[g][ntew_pkg::PH_HUNDRED]    = groups[g][11:8] != 4'd0;
      flags_new[g][ntew_pkg::PH_TENS]       = groups[g][7:0] != 8'd0;
      flags_new[g][ntew_pkg::PH_ONES]       = (groups[g][7:4] >= 4'd2) &&
                                              (groups[g][3:0] != 4'd0);
      flags_new[g][ntew_pkg::PH_SCALE]      = (g != ntew_pkg::GROUPS-1) &&
                                              (groups[g] != 12'd0);
    end
  end

  always_comb begin
    for (int g = 0; g < ntew_pkg::GROUPS; g++) begin
      for (int p = 0; p < ntew_pkg::PHASES; p++) begin
        later[g][p] = (2'(g) > grp) || ((2'(g) == grp) && (3'(p) > ph));
      end
    end
  end

  always_comb begin
    dh       = groups[grp][11:8];
    dt       = groups[grp][7:4];
    dl       = groups[grp][3:0];
    cur_flag = flags[grp][ph];
    cur_last = (flags & later) == '0;
    cur_sep  = first ? ntew_pkg::SEP_NONE :
               (ph == ntew_pkg::PH_ONES) ? ntew_pkg::SEP_HYPHEN : ntew_pkg::SEP_SPACE;
    case (ph)
      ntew_pkg::PH_HUND_DIGIT: cur_word = {1'b0, dh};
      ntew_pkg::PH_HUNDRED:    cur_word = ntew_pkg::TOK_HUNDRED;
      ntew_pkg::PH_TENS: begin
        if (dt >= 4'd2) begin
          cur_word = ntew_pkg::TOK_TENS + {1'b0, dt};
        end else if (dt == 4'd1) begin
          cur_word = ntew_pkg::TOK_TEEN + {1'b0, dl};
        end else begin
          cur_word = {1'b0, dl};
        end
      end
      ntew_pkg::PH_ONES:       cur_word = {1'b0, dl};
      ntew_pkg::PH_SCALE: begin
        case (grp)
          ntew_pkg::GRP_BILLION:  cur_word = ntew_pkg::TOK_BILLION;
          ntew_pkg::GRP_MILLION:  cur_word = ntew_pkg::TOK_MILLION;
          ntew_pkg::GRP_THOUSAND: cur_word = ntew_pkg::TOK_THOUSAND;
          default:                cur_word = ntew_pkg::TOK_ZERO;
        endcase
      end
      default:                 cur_word = ntew_pkg::TOK_ZERO;
    endcase
  end

  assign out_free = !word_valid || !word_stall;
  assign step     = !ctl.start && active && out_free;
  assign emit     = step && (special || cur_flag);
  assign finish   = step && (special || (cur_flag && cur_last));

  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      word_valid <= 1'b0;
      done       <= 1'b0;
    end else begin
      done       <= finish;
      word_valid <= emit || (word_valid && word_stall);
      if (ctl.start) begin
        active <= 1'b1;
      end else if (finish) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      flags   <= flags_new;
      grp     <= ntew_pkg::GRP_BILLION;
      ph      <= ntew_pkg::PH_HUND_DIGIT;
      first   <= 1'b1;
      err     <= ctl.too_big;
      special <= ctl.too_big || (bcd == '0);
    end else if (active && out_free) begin
      if (special) begin
        word      <= ntew_pkg::TOK_ZERO;
        separator <= ntew_pkg::SEP_NONE;
        too_big   <= err;
        last      <= 1'b1;
      end else begin
        if (cur_flag) begin
          word      <= cur_word;
          separator <= cur_sep;
          too_big   <= 1'b0;
          last      <= cur_last;
          first     <= 1'b0;
        end
        if (ph == ntew_pkg::PH_SCALE) begin
          ph  <= ntew_pkg::PH_HUND_DIGIT;
          grp <= ntew_pkg::grp_t'(grp + 2'd1);
        end else begin
          ph  <= ntew_pkg::phase_t'(ph + 3'd1);
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ bench/ntew_word_checker.sv @@
// Checker that predicts the word beats of each number and compares them with the block.
module ntew_word_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         value_valid,
  input  logic                         value_stall,
  input  logic [ntew_pkg::VALUE_W-1:0] value,
  input  logic                         word_valid,
  input  logic                         word_stall,
  input  logic [ntew_pkg::WORD_W-1:0]  word,
  input  logic [ntew_pkg::SEP_W-1:0]   separator,
  input  logic                         too_big,
  input  logic                         last,
  output int                           mismatches,
  output int                           pending,
  output int                           words_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VALUE_W = ntew_pkg::VALUE_W;
  localparam int WORD_W  = ntew_pkg::WORD_W;
  localparam int GROUPS  = ntew_pkg::GROUPS;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    ntew_pkg::sep_t    sep;
    logic              too_big;
    logic              last;
  } word_beat_t;

  word_beat_t spelled_q[$];
  word_beat_t run_q[$];
  int         fail_cnt;
  int         beat_cnt;

  function automatic void put_token(input logic [WORD_W-1:0] code, input logic hyphen);
    word_beat_t b;
    b.word    = code;
    b.too_big = 1'b0;
    b.last    = 1'b0;
    if (run_q.size() == 0) begin
      b.sep = ntew_pkg::SEP_NONE;
    end else if (hyphen) begin
      b.sep = ntew_pkg::SEP_HYPHEN;
    end else begin
      b.sep = ntew_pkg::SEP_SPACE;
    end
    run_q.push_back(b);
  endfunction

  function automatic void put_group(input int unsigned g);
    int unsigned h;
    int unsigned r;
    h = g / 100;
    r = g % 100;
    if (h != 0) begin
      put_token(WORD_W'(h), 1'b0);
      put_token(ntew_pkg::TOK_HUNDRED, 1'b0);
    end
    if (r != 0) begin
      if (r < 20) begin
        put_token(WORD_W'(r), 1'b0);
      end else begin
        put_token(ntew_pkg::TOK_TENS + WORD_W'(r / 10), 1'b0);
        if (r % 10 != 0) begin
          put_token(WORD_W'(r % 10), 1'b1);
        end
      end
    end
  endfunction

  function automatic void spell_number(input logic [VALUE_W-1:0] v);
    longint unsigned   n;
    int unsigned       grp[4];
    logic [WORD_W-1:0] scale[4];
    word_beat_t        b;
    n = v;
    run_q.delete();
    if (v > ntew_pkg::MAX_VALUE || v == '0) begin
      b.word    = ntew_pkg::TOK_ZERO;
      b.sep     = ntew_pkg::SEP_NONE;
      b.too_big = (v > ntew_pkg::MAX_VALUE);
      b.last    = 1'b1;
      run_q.push_back(b);
    end else begin
      grp[0] = int'(n / 64'd1000000000);
      grp[1] = int'((n / 64'd1000000) % 64'd1000);
      grp[2] = int'((n / 64'd1000) % 64'd1000);
      grp[3] = int'(n % 64'd1000);
      scale[0] = ntew_pkg::TOK_BILLION;
      scale[1] = ntew_pkg::TOK_MILLION;
      scale[2] = ntew_pkg::TOK_THOUSAND;
      scale[3] = ntew_pkg::TOK_ZERO;
      for (int i = 0; i < GROUPS; i++) begin
        if (grp[i] != 0) begin
          put_group(grp[i]);
          if (i < GROUPS - 1) begin
            put_token(scale[i], 1'b0);
          end
        end
      end
      b = run_q.pop_back();
      b.last = 1'b1;
      run_q.push_back(b);
    end
    foreach (run_q[i]) begin
      spelled_q.push_back(run_q[i]);
    end
  endfunction

  always @(posedge clk) begin
    word_beat_t want;
    if (rst) begin
      spelled_q.delete();
    end else begin
      if (value_valid && !value_stall) begin
        spell_number(value);
      end
      if (word_valid && !word_stall) begin
        beat_cnt++;
        if (spelled_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10) begin
            $display("%0t: unexpected word beat: word %0d sep %0d too_big %0b last %0b",
                     $realtime, word, separator, too_big, last);
          end
        end else begin
          want = spelled_q.pop_front();
          if (want.word !== word || want.sep !== separator ||
              want.too_big !== too_big || want.last !== last) begin
            fail_cnt++;
            if (fail_cnt <= 10) begin
              $display("%0t: expected word %0d sep %0d too_big %0b last %0b",
                       $realtime, want.word, want.sep, want.too_big, want.last);
              $display("%0t:      got word %0d sep %0d too_big %0b last %0b",
                       $realtime, word, separator, too_big, last);
            end
          end
        end
      end
    end
    mismatches    <= fail_cnt;
    pending       <= spelled_q.size();
    words_checked <= beat_cnt;
  end

endmodule

@@ bench/tb.sv @@
// Testbench top: drives numbers and word-side stalls, and reports the verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VALUE_W      = ntew_pkg::VALUE_W;
  localparam int WORD_W       = ntew_pkg::WORD_W;
  localparam int SEP_W        = ntew_pkg::SEP_W;
  localparam int GROUPS       = ntew_pkg::GROUPS;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_ITEMS = 200;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               value_valid = 1'b0;
  logic [VALUE_W-1:0] value = '0;
  logic               word_stall = 1'b0;
  logic               value_stall;
  logic               word_valid;
  logic [WORD_W-1:0]  word;
  logic [SEP_W-1:0]   separator;
  logic               too_big;
  logic               last;

  int mismatches;
  int pending;
  int words_checked;
  int cycles;
  int items_sent;
  int out_of_range;
  int zero_items;

  logic [VALUE_W-1:0] numbers_q[$];

  always #6 clk = ~clk;

  number_to_english_words_unit dut (
    .clk         (clk),
    .rst         (rst),
    .value_valid (value_valid),
    .value_stall (value_stall),
    .value       (value),
    .word_valid  (word_valid),
    .word_stall  (word_stall),
    .word        (word),
    .separator   (separator),
    .too_big     (too_big),
    .last        (last)
  );

  ntew_word_checker spelling_check (
    .clk           (clk),
    .rst           (rst),
    .value_valid   (value_valid),
    .value_stall   (value_stall),
    .value         (value),
    .word_valid    (word_valid),
    .word_stall    (word_stall),
    .word          (word),
    .separator     (separator),
    .too_big       (too_big),
    .last          (last),
    .mismatches    (mismatches),
    .pending       (pending),
    .words_checked (words_checked)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 15);
    if (r < 8) begin
      return 0;
    end else if (r < 14) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(16, 40);
  endfunction

  function automatic logic [VALUE_W-1:0] random_number();
    longint unsigned n;
    int              mode;
    mode = $urandom_range(0, 9);
    case (mode)
      0, 1: begin
        n = {$urandom, $urandom};
      end
      2: begin
        n = 64'(ntew_pkg::MAX_VALUE) - 64'd2 + 64'($urandom_range(0, 4));
      end
      3: begin
        n = $urandom_range(0, 999);
      end
      default: begin
        n = 0;
        for (int i = 0; i < GROUPS; i++) begin
          n = n * 1000 + (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 999));
        end
      end
    endcase
    return VALUE_W'(n);
  endfunction

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d beats pending.", cycles, pending);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin : sender
    logic [VALUE_W-1:0] v;
    int                 idle;
    int                 calm;
    calm = 0;
    numbers_q = '{40'd0, 40'd1, 40'd7, 40'd13, 40'd19, 40'd20, 40'd45, 40'd99, 40'd100,
                  40'd110, 40'd999, 40'd1000, 40'd1001, 40'd1000000, 40'd1000000000,
                  40'd999999999999, 40'd1000000000000, 40'hFF_FFFF_FFFF, 40'd777777777777,
                  40'd123456789012, 40'd100100100100, 40'd12000021, 40'd80000000080};
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      numbers_q.push_back(random_number());
    end
    while (rst) @(posedge clk);
    while (numbers_q.size() != 0) begin
      v = numbers_q.pop_front();
      if (v > ntew_pkg::MAX_VALUE) begin
        out_of_range++;
      end else if (v == '0) begin
        zero_items++;
      end
      if (calm > 0) begin
        calm--;
      end else if ($urandom_range(0, 19) == 0) begin
        calm = $urandom_range(10, 30);
      end
      idle = (calm > 0) ? 0 : gap_len();
      if (idle > 0) begin
        value_valid <= 1'b0;
        repeat (idle) @(posedge clk);
      end
      value_valid <= 1'b1;
      value       <= v;
      @(posedge clk);
      while (value_stall) @(posedge clk);
      items_sent++;
    end
    value_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    $display("Spelled %0d numbers (%0d out of range, %0d zero) as %0d word beats.",
             items_sent, out_of_range, zero_items, words_checked);
    $display("Word side held off once for %0d cycles; random gaps on both channels.",
             HOLD_CYCLES);
    if (mismatches == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // The long hold lets the block fill up so that its input stalls while numbers keep coming.
  initial begin : receiver
    int r;
    bit held;
    held = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      r = $urandom_range(0, 15);
      if (!held && words_checked >= 30) begin
        held = 1'b1;
        word_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (r < 10) begin
        word_stall <= 1'b0;
        @(posedge clk);
      end else if (r < 14) begin
        word_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else if (r == 14) begin
        word_stall <= 1'b1;
        repeat ($urandom_range(16, 40)) @(posedge clk);
      end else begin
        word_stall <= 1'b0;
        repeat ($urandom_range(40, 120)) @(posedge clk);
      end
    end
  end

endmodule
